/* hw/rtl/chrl_pkg.sv */
// Package for the consistent-hash ring lookup block.
// Holds field widths, function and status codes, and parameter defaults.
// No dependencies.
package chrl_pkg;
  localparam int HASH_W = 64;
  localparam int OWNER_W = 4;
  localparam int STATUS_W = 2;
  localparam int RF_W = 4;
  localparam int OWNERS = 1 << OWNER_W;
  localparam int ENTRY_W = HASH_W + OWNER_W;

  localparam int RING_POINTS_DEF = 256;
  localparam int MAX_REPLICAS_DEF = 8;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;
endpackage

/* hw/rtl/consistent_hash_ring_lookup_top.sv */
// Consistent-hash ring lookup: sorted point table in one memory, binary search,
// insert by shifting, and a ring walk that collects distinct owners.
// Depends on chrl_pkg.
//
// Usage: the input channel (in_valid/in_stall) carries one transaction per item:
// in_func selects insert or lookup, in_point_hash the hash, in_node_id the owner.
// The result channel (out_valid/out_stall) gives owner, status and last.
// An insert gives one result; a lookup gives 1..replication_factor results (0
// counts as 1, above MAX_REPLICAS as MAX_REPLICAS), out_last on the final one.
// A lookup on an empty ring gives one result with status empty. The cfg channel
// (cfg_valid/cfg_ready) writes replication_factor and is always ready. One item
// is taken at a time; in_stall is high until its last result is loaded.
// Binary search does one registered memory read and one compare per halving; a
// new insert moves each later point up by a read and a write, and a lookup reads
// each point walked and loads each result in turn, all through one read port.
// Reset clears the point count, sets replication_factor to 1 and empties the
// output register. When the receiver stalls, the result holds in the output
// register and the sequencer waits before loading the next one.
module consistent_hash_ring_lookup_top #(
  parameter int RING_POINTS = chrl_pkg::RING_POINTS_DEF,
  parameter int MAX_REPLICAS = chrl_pkg::MAX_REPLICAS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [chrl_pkg::HASH_W-1:0]   in_point_hash,
  input  logic [chrl_pkg::OWNER_W-1:0]  in_node_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [chrl_pkg::OWNER_W-1:0]  out_owner_node,
  output logic [chrl_pkg::STATUS_W-1:0] out_status,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [chrl_pkg::RF_W-1:0]     cfg_replication_factor
);
  import chrl_pkg::*;

  localparam int AW = $clog2(RING_POINTS);
  localparam int CW = $clog2(RING_POINTS + 1);
  localparam int RW = $clog2(MAX_REPLICAS + 1);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_SRCH = 10'b0000000010,
    S_SCMP = 10'b0000000100,
    S_ICHK = 10'b0000001000,
    S_SHRD = 10'b0000010000,
    S_SHWR = 10'b0000100000,
    S_WALK = 10'b0001000000,
    S_WCMP = 10'b0010000000,
    S_PUSH = 10'b0100000000,
    S_FIN  = 10'b1000000000
  } state_t;

  logic [ENTRY_W-1:0] mem [RING_POINTS];
  logic [ENTRY_W-1:0] rd_r;
  logic [AW-1:0] raddr;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt, lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [CW-1:0] i_r, i_nxt, vis_r, vis_nxt;
  logic [RW-1:0] n_r, n_nxt, want_r, want_nxt;
  logic [OWNERS-1:0] seen_r, seen_nxt;
  logic [RF_W-1:0] rf_r;
  logic func_r, func_nxt;
  logic [HASH_W-1:0] h_r, h_nxt;
  logic [OWNER_W-1:0] node_r, node_nxt, pend_r, pend_nxt, cand_r, cand_nxt;
  logic pend_v_r, pend_v_nxt;
  status_t st_r, st_nxt;
  logic out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [OWNER_W-1:0] out_owner_r, out_owner_nxt;
  status_t out_status_r, out_status_nxt;
  logic slot_free;
  logic [CW:0] mid_sum;
  logic [OWNER_W-1:0] rd_owner;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_owner_node = out_owner_r;
  assign out_status = out_status_r;
  assign out_last = out_last_r;
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign rd_owner = rd_r[OWNER_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[raddr];
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    mid_nxt = mid_r;
    i_nxt = i_r;
    vis_nxt = vis_r;
    n_nxt = n_r;
    want_nxt = want_r;
    seen_nxt = seen_r;
    func_nxt = func_r;
    h_nxt = h_r;
    node_nxt = node_r;
    pend_nxt = pend_r;
    pend_v_nxt = pend_v_r;
    cand_nxt = cand_r;
    st_nxt = st_r;
    raddr = mid_r[AW-1:0];
    wr_en = 1'b0;
    wr_addr = i_r[AW-1:0];
    wr_data = rd_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_owner_nxt = out_owner_r;
    out_status_nxt = out_status_r;
    out_last_nxt = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt = in_func;
          h_nxt = in_point_hash;
          node_nxt = in_node_id;
          lo_nxt = '0;
          hi_nxt = count_r;
          pend_v_nxt = 1'b0;
          pend_nxt = '0;
          st_nxt = ST_OK;
          seen_nxt = '0;
          n_nxt = '0;
          vis_nxt = '0;
          if (rf_r == '0) begin
            want_nxt = RW'(1);
          end else if (32'(rf_r) > MAX_REPLICAS) begin
            want_nxt = RW'(MAX_REPLICAS);
          end else begin
            want_nxt = RW'(rf_r);
          end
          if (in_func == FUNC_LOOKUP && count_r == '0) begin
            st_nxt = ST_EMPTY;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          mid_nxt = mid_sum[CW:1];
          raddr = mid_sum[AW:1];
          state_nxt = S_SCMP;
        end else if (func_r == FUNC_LOOKUP) begin
          i_nxt = (lo_r >= count_r) ? '0 : lo_r;
          state_nxt = S_WALK;
        end else if (lo_r != '0) begin
          raddr = AW'(lo_r - CW'(1));
          state_nxt = S_ICHK;
        end else if (count_r >= CW'(RING_POINTS)) begin
          st_nxt = ST_FULL;
          state_nxt = S_FIN;
        end else begin
          i_nxt = count_r;
          state_nxt = S_SHRD;
        end
      end
      S_SCMP: begin
        if (rd_r[ENTRY_W-1:OWNER_W] > h_r) begin
          hi_nxt = mid_r;
        end else begin
          lo_nxt = mid_r + CW'(1);
        end
        state_nxt = S_SRCH;
      end
      S_ICHK: begin
        if (rd_r[ENTRY_W-1:OWNER_W] == h_r) begin
          wr_en = 1'b1;
          wr_addr = AW'(lo_r - CW'(1));
          wr_data = {h_r, node_r};
          state_nxt = S_FIN;
        end else if (count_r >= CW'(RING_POINTS)) begin
          st_nxt = ST_FULL;
          state_nxt = S_FIN;
        end else begin
          i_nxt = count_r;
          state_nxt = S_SHRD;
        end
      end
      S_SHRD: begin
        if (i_r > lo_r) begin
          raddr = AW'(i_r - CW'(1));
          state_nxt = S_SHWR;
        end else begin
          wr_en = 1'b1;
          wr_addr = lo_r[AW-1:0];
          wr_data = {h_r, node_r};
          count_nxt = count_r + CW'(1);
          state_nxt = S_FIN;
        end
      end
      S_SHWR: begin
        wr_en = 1'b1;
        wr_addr = i_r[AW-1:0];
        wr_data = rd_r;
        i_nxt = i_r - CW'(1);
        state_nxt = S_SHRD;
      end
      S_WALK: begin
        if (vis_r < count_r && n_r < want_r) begin
          raddr = i_r[AW-1:0];
          state_nxt = S_WCMP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_WCMP: begin
        vis_nxt = vis_r + CW'(1);
        i_nxt = (i_r + CW'(1) >= count_r) ? '0 : i_r + CW'(1);
        state_nxt = S_WALK;
        if (!seen_r[rd_owner]) begin
          seen_nxt[rd_owner] = 1'b1;
          n_nxt = n_r + RW'(1);
          if (pend_v_r) begin
            cand_nxt = rd_owner;
            state_nxt = S_PUSH;
          end else begin
            pend_nxt = rd_owner;
            pend_v_nxt = 1'b1;
          end
        end
      end
      S_PUSH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_owner_nxt = pend_r;
          out_status_nxt = ST_OK;
          out_last_nxt = 1'b0;
          pend_nxt = cand_r;
          state_nxt = S_WALK;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_owner_nxt = pend_r;
          out_status_nxt = st_r;
          out_last_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      rf_r <= RF_W'(1);
      out_valid_r <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r <= pend_v_nxt;
      if (cfg_valid && cfg_ready) begin
        rf_r <= cfg_replication_factor;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    mid_r <= mid_nxt;
    i_r <= i_nxt;
    vis_r <= vis_nxt;
    n_r <= n_nxt;
    want_r <= want_nxt;
    seen_r <= seen_nxt;
    func_r <= func_nxt;
    h_r <= h_nxt;
    node_r <= node_nxt;
    pend_r <= pend_nxt;
    cand_r <= cand_nxt;
    st_r <= st_nxt;
    out_owner_r <= out_owner_nxt;
    out_status_r <= out_status_nxt;
    out_last_r <= out_last_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(RING_POINTS))
    else $error("point count above table size");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_last_r)
    else $error("error status without last");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != S_IDLE)
    else $error("sequencer idle after accepted transaction");
endmodule

/* tb/tb.sv */
// Testbench for consistent_hash_ring_lookup_top: directed table, then random phases.
// Keeps its own sorted ring; predicts owner/status/last unless a table row is typed.
// Depends on chrl_pkg and the RTL top only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import chrl_pkg::*;

  localparam int RING_MAX = RING_POINTS_DEF;
  localparam int REPL_MAX = MAX_REPLICAS_DEF;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE = 40;

  typedef struct {
    logic [OWNER_W-1:0] owner;
    status_t            st;
    logic               last;
  } ring_res_t;

  typedef struct {
    logic               func;
    logic [HASH_W-1:0]  hash;
    logic [OWNER_W-1:0] node;
    bit                 typed;
    logic [OWNER_W-1:0] owner;
    status_t            st;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_func = 1'b0;
  logic [HASH_W-1:0]   in_point_hash = '0;
  logic [OWNER_W-1:0]  in_node_id = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [OWNER_W-1:0]  out_owner_node;
  logic [STATUS_W-1:0] out_status;
  logic                out_last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [RF_W-1:0]     cfg_replication_factor = '0;

  logic [HASH_W-1:0]  ring_hash [RING_MAX];
  logic [OWNER_W-1:0] ring_owner [RING_MAX];
  int unsigned        ring_count = 0;
  logic [RF_W-1:0]    repl_factor = 4'd1;
  ring_res_t          pending_q[$];

  int  errors = 0;
  int  cycles = 0;
  int  send_idle = 0;
  int  stall_pct = 0;
  int  hold_left = 0;
  int  node_span = 15;

  consistent_hash_ring_lookup_top u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_func                (in_func),
    .in_point_hash          (in_point_hash),
    .in_node_id             (in_node_id),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_owner_node         (out_owner_node),
    .out_status             (out_status),
    .out_last               (out_last),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_replication_factor (cfg_replication_factor)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("consistent_hash_ring_lookup_top test failed");
      $finish;
    end
  end

  function automatic int unsigned ring_first_above(logic [HASH_W-1:0] h);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = ring_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (ring_hash[mid] > h) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  task automatic ring_step(input logic func, input logic [HASH_W-1:0] h,
                           input logic [OWNER_W-1:0] node, output ring_res_t res[$]);
    int unsigned pos, idx, visited, want;
    bit seen [OWNERS];
    ring_res_t r;
    res = {};
    r.owner = '0;
    r.st = ST_OK;
    r.last = 1'b1;
    if (func == FUNC_INSERT) begin
      pos = ring_first_above(h);
      if (pos > 0 && ring_hash[pos-1] == h) begin
        ring_owner[pos-1] = node;
      end else if (ring_count >= RING_MAX) begin
        r.st = ST_FULL;
      end else begin
        for (int i = ring_count; i > pos; i--) begin
          ring_hash[i] = ring_hash[i-1];
          ring_owner[i] = ring_owner[i-1];
        end
        ring_hash[pos] = h;
        ring_owner[pos] = node;
        ring_count++;
      end
      res = {res, r};
    end else if (ring_count == 0) begin
      r.st = ST_EMPTY;
      res = {res, r};
    end else begin
      want = (repl_factor == 0) ? 1 : repl_factor;
      if (want > REPL_MAX) want = REPL_MAX;
      foreach (seen[i]) seen[i] = 1'b0;
      idx = ring_first_above(h);
      if (idx >= ring_count) idx = 0;
      for (visited = 0; visited < ring_count && res.size() < want; visited++) begin
        if (!seen[ring_owner[idx]]) begin
          seen[ring_owner[idx]] = 1'b1;
          r.owner = ring_owner[idx];
          r.last = 1'b0;
          res = {res, r};
        end
        idx = (idx + 1 >= ring_count) ? 0 : idx + 1;
      end
      res[res.size()-1].last = 1'b1;
    end
  endtask

  // check every accepted result against the queue
  initial begin
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result owner=%0d status=%0d last=%0b",
                   $time, out_owner_node, out_status, out_last);
        end else begin
          ring_res_t e;
          e = pending_q.pop_front();
          if (out_owner_node !== e.owner || out_status !== e.st || out_last !== e.last) begin
            errors++;
            $display("%0t: mismatch expected owner=%0d status=%0d last=%0b, got %0d %0d %0b",
                     $time, e.owner, e.st, e.last, out_owner_node, out_status, out_last);
          end
        end
      end
    end
  end

  // hold out_stall per phase, or for a counted stretch
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_item(input logic func, input logic [HASH_W-1:0] h,
                           input logic [OWNER_W-1:0] node, input bit typed,
                           input ring_res_t typed_res);
    ring_res_t res[$];
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_point_hash <= h;
    in_node_id <= node;
    do @(posedge clk); while (in_stall);
    ring_step(func, h, node, res);
    if (typed) pending_q = {pending_q, typed_res};
    else pending_q = {pending_q, res};
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_rf(input logic [RF_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_replication_factor <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    repl_factor = v;
  endtask

  function automatic logic [HASH_W-1:0] pick_hash();
    logic [HASH_W-1:0] h;
    h = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: h = '0;
      1: h = '1;
      2, 3, 4: if (ring_count > 0) h = ring_hash[$urandom_range(0, ring_count-1)];
      5: if (ring_count > 0) h = ring_hash[$urandom_range(0, ring_count-1)] - 1;
      default: ;
    endcase
    return h;
  endfunction

  task automatic random_items(input int n, input int lookup_pct);
    ring_res_t none;
    none = '{owner: '0, st: ST_OK, last: 1'b0};
    repeat (n) begin
      send_item($urandom_range(99) < lookup_pct ? FUNC_LOOKUP : FUNC_INSERT,
                pick_hash(), 4'($urandom_range(0, node_span)), 1'b0, none);
    end
  endtask

  task automatic run_phase(input logic [RF_W-1:0] rf, input int idle, input int stall,
                           input int n);
    drain();
    write_rf(rf);
    send_idle = idle;
    stall_pct = stall;
    node_span = $urandom_range(1, 15);
    random_items(n, 60);
  endtask

  initial begin
    dir_row_t  dir_tab [20];
    ring_res_t tr;
    ring_res_t none;
    none = '{owner: '0, st: ST_OK, last: 1'b0};
    dir_tab = '{
      '{FUNC_LOOKUP, 64'h0,                   4'd0,  1'b1, 4'd0, ST_EMPTY},
      '{FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 4'd0, ST_EMPTY},
      '{FUNC_INSERT, 64'h0,                   4'd15, 1'b1, 4'd0, ST_OK},
      '{FUNC_LOOKUP, 64'h0,                   4'd0,  1'b0, 4'd0, ST_OK},
      '{FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  1'b1, 4'd0, ST_OK},
      '{FUNC_INSERT, 64'd1000,                4'd5,  1'b1, 4'd0, ST_OK},
      '{FUNC_INSERT, 64'd1000,                4'd9,  1'b1, 4'd0, ST_OK},
      '{FUNC_LOOKUP, 64'd0,                   4'd0,  1'b0, 4'd0, ST_OK},
      '{FUNC_LOOKUP, 64'd999,                 4'd0,  1'b0, 4'd0, ST_OK},
      '{FUNC_LOOKUP, 64'd1000,                4'd0,  1'b0, 4'd0, ST_OK},
      '{FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  1'b0, 4'd0, ST_OK},
      '{FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, 4'd0,  1'b0, 4'd0, ST_OK},
      '{FUNC_INSERT, 64'h5555_5555_5555_5555, 4'd10, 1'b1, 4'd0, ST_OK},
      '{FUNC_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 4'd5,  1'b1, 4'd0, ST_OK},
      '{FUNC_INSERT, 64'h8000_0000_0000_0000, 4'd9,  1'b1, 4'd0, ST_OK},
      '{FUNC_LOOKUP, 64'h5555_5555_5555_5555, 4'd0,  1'b0, 4'd0, ST_OK},
      '{FUNC_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 4'd0,  1'b0, 4'd0, ST_OK},
      '{FUNC_INSERT, 64'h0,                   4'd3,  1'b1, 4'd0, ST_OK},
      '{FUNC_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 4'd0,  1'b0, 4'd0, ST_OK},
      '{FUNC_LOOKUP, 64'h1234_5678_9ABC_DEF0, 4'd0,  1'b0, 4'd0, ST_OK}
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      tr = '{owner: dir_tab[i].owner, st: dir_tab[i].st, last: 1'b1};
      send_item(dir_tab[i].func, dir_tab[i].hash, dir_tab[i].node, dir_tab[i].typed, tr);
    end

    run_phase(4'd0, 0, 0, 50);
    run_phase(4'd15, 77, 0, 50);
    drain();
    write_rf(4'd8);
    send_idle = 0;
    stall_pct = 77;
    hold_left = 400;
    random_items(60, 60);
    run_phase(4'd3, 33, 33, 50);
    run_phase(4'd1, 0, 0, 10);

    drain();
    write_rf(4'($urandom_range(2, 7)));
    send_idle = 33;
    stall_pct = 33;
    node_span = 15;
    while (ring_count < RING_MAX)
      send_item(FUNC_INSERT, {$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b0, none);
    random_items(30, 50);
    run_phase(4'd15, 0, 77, 15);

    drain();
    if (errors == 0) begin
      $display("consistent_hash_ring_lookup_top test passed");
    end else begin
      $display("consistent_hash_ring_lookup_top test failed");
    end
    $finish;
  end
endmodule

/* files.f */
hw/rtl/chrl_pkg.sv
hw/rtl/consistent_hash_ring_lookup_top.sv
tb/tb.sv
